FILE: rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared types and constants of the motor report frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfp_pkg;

    localparam int REPORT_PAYLOAD_BYTES = 12;
    localparam int PAYLOAD_IDX_W        = $clog2(REPORT_PAYLOAD_BYTES);
    localparam int QUEUE_DEPTH_DEF      = 2;
    localparam int CFG_IDX_W            = 3;

    // report one fault flags keep the top five bits of the second payload byte
    localparam logic [7:0] FAULT_LOW_MASK = 8'hF8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD     = 3'd0,
        REG_ADDRESS  = 3'd1,
        REG_END      = 3'd2,
        REG_ONE_CODE = 3'd3,
        REG_TWO_CODE = 3'd4
    } cfg_reg_e;

    typedef enum logic [1:0] {
        KIND_REPORT_ONE = 2'd0,
        KIND_REPORT_TWO = 2'd1,
        KIND_OTHER      = 2'd2,
        KIND_BAD_LENGTH = 2'd3
    } frame_kind_e;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] address_byte;
        logic [7:0] end_byte;
        logic [7:0] report_one_code;
        logic [7:0] report_two_code;
    } cfg_t;

    // one checked frame, as handed from the parser to the formatter
    typedef struct packed {
        frame_kind_e                               kind;
        logic [7:0]                                command;
        logic [REPORT_PAYLOAD_BYTES-1:0][7:0]      payload;
    } frame_t;

endpackage : mrfp_pkg

`default_nettype wire

FILE: rtl/mrfp_front.sv
// ----------------------------------------------------------------------------
// mrfp_front
// Byte-per-cycle frame hunter (stalls only as an end byte meets a full queue):
// checks address, xor and end byte, stores payload, classifies each good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_front
    import mrfp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   rx_valid,
    output logic        rx_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic   queue_full,
    output logic        push,
    output frame_t      push_frame
);

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_ADDR = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_BODY = 6'b001000,
        PH_XOR  = 6'b010000,
        PH_END  = 6'b100000
    } phase_e;

    phase_e     phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] command_reg, command_next;
    logic [REPORT_PAYLOAD_BYTES-1:0][7:0] payload_reg;

    logic       accept;
    logic [7:0] body_idx;
    logic [7:0] seen_inc;
    logic       store_en;
    logic       full_length;

    // only the end phase can produce an item, so only then can a full queue stall
    assign rx_ready = !((phase_reg == PH_END) && queue_full);
    assign accept   = rx_valid && rx_ready;
    assign body_idx = bytes_seen_reg - 8'd1;
    assign seen_inc = bytes_seen_reg + 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_xor_next  = running_xor_reg;
        command_next      = command_reg;
        store_en          = 1'b0;
        push              = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    phase_next = (rx_byte == cfg.address_byte) ? PH_LEN : PH_HUNT;
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        frame_length_next = rx_byte;
                        running_xor_next  = rx_byte;
                        bytes_seen_next   = 8'd0;
                        phase_next        = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    if (bytes_seen_reg == 8'd0)
                    begin
                        command_next = rx_byte;
                    end
                    else if (body_idx < 8'(REPORT_PAYLOAD_BYTES))
                    begin
                        store_en = 1'b1;
                    end
                    bytes_seen_next = seen_inc;
                    if (seen_inc >= frame_length_reg)
                    begin
                        phase_next = PH_XOR;
                    end
                end
                PH_XOR:
                begin
                    phase_next = (rx_byte == running_xor_reg) ? PH_END : PH_HUNT;
                end
                PH_END:
                begin
                    phase_next = PH_HUNT;
                    push       = (rx_byte == cfg.end_byte);
                end
                default:
                begin
                    phase_next = (rx_byte == cfg.head_byte) ? PH_ADDR : PH_HUNT;
                end
            endcase
        end
    end

    // classification; report one wins when both codes are equal
    assign full_length = (frame_length_reg == 8'(REPORT_PAYLOAD_BYTES + 1));

    always_comb
    begin
        push_frame.command = command_reg;
        push_frame.payload = payload_reg;
        if (command_reg == cfg.report_one_code)
        begin
            push_frame.kind = full_length ? KIND_REPORT_ONE : KIND_BAD_LENGTH;
        end
        else if (command_reg == cfg.report_two_code)
        begin
            push_frame.kind = full_length ? KIND_REPORT_TWO : KIND_BAD_LENGTH;
        end
        else
        begin
            push_frame.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= 8'd0;
            bytes_seen_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            command_reg      <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_xor_reg  <= running_xor_next;
            command_reg      <= command_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[body_idx[PAYLOAD_IDX_W-1:0]] <= rx_byte;
        end
    end

    a_push_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && (phase_reg == PH_END)))
        else $error("frame pushed outside the end phase");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_END)) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after end byte");

endmodule : mrfp_front

`default_nettype wire

FILE: rtl/mrfp_queue.sv
// ----------------------------------------------------------------------------
// mrfp_queue
// Short frame queue between the parser and the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_queue
    import mrfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output frame_t      head_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_frame = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full frame queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty frame queue");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("frame queue count out of range");

endmodule : mrfp_queue

`default_nettype wire

FILE: rtl/mrfp_back.sv
// ----------------------------------------------------------------------------
// mrfp_back
// Takes queued frames and lays out the report words in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_back
    import mrfp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   queue_not_empty,
    input  wire frame_t head_frame,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [1:0]  frame_kind,
    output logic [7:0]  command_code,
    output logic [15:0] fault_flags,
    output logic [15:0] word_zero,
    output logic [15:0] word_one,
    output logic [15:0] word_two,
    output logic [15:0] word_three,
    output logic [15:0] word_four,
    output logic [15:0] word_five
);

    logic        valid_reg;
    frame_kind_e kind_reg;
    logic [7:0]  command_reg;
    logic [15:0] fault_reg, fault_next;
    logic [5:0][15:0] word_reg, word_next;
    logic [REPORT_PAYLOAD_BYTES-1:0][7:0] p;

    assign pop = queue_not_empty && (!valid_reg || out_ready);
    assign p   = head_frame.payload;

    always_comb
    begin
        fault_next = 16'd0;
        word_next  = '0;
        case (head_frame.kind)
            KIND_REPORT_ONE:
            begin
                fault_next   = {p[0], p[1] & FAULT_LOW_MASK};
                word_next[0] = {p[2], p[3]};
                word_next[1] = {p[4], p[5]};
                word_next[2] = {p[6], p[7]};
                word_next[3] = {p[8], p[9]};
                word_next[4] = {p[10], p[11]};
            end
            KIND_REPORT_TWO:
            begin
                word_next[0] = {p[0], p[1]};
                word_next[1] = {p[2], p[3]};
                word_next[2] = {p[4], p[5]};
                word_next[3] = {p[6], p[7]};
                word_next[4] = {p[8], p[9]};
                word_next[5] = {p[10], p[11]};
            end
            default:
            begin
                fault_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= head_frame.kind;
            command_reg <= head_frame.command;
            fault_reg   <= fault_next;
            word_reg    <= word_next;
        end
    end

    assign out_valid    = valid_reg;
    assign frame_kind   = kind_reg;
    assign command_code = command_reg;
    assign fault_flags  = fault_reg;
    assign word_zero    = word_reg[0];
    assign word_one     = word_reg[1];
    assign word_two     = word_reg[2];
    assign word_three   = word_reg[3];
    assign word_four    = word_reg[4];
    assign word_five    = word_reg[5];

endmodule : mrfp_back

`default_nettype wire

FILE: rtl/motor_report_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_report_frame_parser
// Serial frame deframer with xor check for motor status reports.
// Throughput: one byte per cycle; a byte stalls only when the end byte of a
// frame with a good xor meets a full frame queue.
// A report is queued at its end byte, then moved into the output register.
// Reset: parser hunts for a head byte, queue and output empty, config registers zero.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_report_frame_parser
    import mrfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 rx_valid,
    output logic                      rx_ready,
    input  wire logic [7:0]           rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                frame_kind,
    output logic [7:0]                command_code,
    output logic [15:0]               fault_flags,
    output logic [15:0]               word_zero,
    output logic [15:0]               word_one,
    output logic [15:0]               word_two,
    output logic [15:0]               word_three,
    output logic [15:0]               word_four,
    output logic [15:0]               word_five
);

    cfg_t   cfg_reg;
    logic   push;
    frame_t push_frame;
    logic   queue_full;
    logic   pop;
    logic   queue_not_empty;
    frame_t head_frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEAD:     cfg_reg.head_byte       <= cfg_data;
                REG_ADDRESS:  cfg_reg.address_byte    <= cfg_data;
                REG_END:      cfg_reg.end_byte        <= cfg_data;
                REG_ONE_CODE: cfg_reg.report_one_code <= cfg_data;
                REG_TWO_CODE: cfg_reg.report_two_code <= cfg_data;
                default:      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    mrfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_frame (push_frame)
    );

    mrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head_frame (head_frame)
    );

    mrfp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head_frame      (head_frame),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_kind      (frame_kind),
        .command_code    (command_code),
        .fault_flags     (fault_flags),
        .word_zero       (word_zero),
        .word_one        (word_one),
        .word_two        (word_two),
        .word_three      (word_three),
        .word_four       (word_four),
        .word_five       (word_five)
    );

endmodule : motor_report_frame_parser

`default_nettype wire
